// ===== hw/rtl/nv21_block_to_rgb_top_macros.svh =====
// Assertion macros for the NV21 block to RGB converter.
`ifndef NV21_BLOCK_TO_RGB_TOP_MACROS_SVH
`define NV21_BLOCK_TO_RGB_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NRGB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nv21rgb: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define NRGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nv21rgb: assertion failed");

`endif

// ===== hw/rtl/nv21rgb_pkg.sv =====
// Types and constants shared by the NV21 block to RGB converter.
package nv21rgb_pkg;

    // Signed width that holds every product and sum before the shift.
    localparam int TERM_W = 21;
    typedef logic signed [TERM_W-1:0] t_term;

    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;
    localparam int         FRAC_BITS     = 10;
    localparam logic [7:0] PIXEL_MAX     = 8'd255;

    localparam t_term LUMA_GAIN  = 21'sd1192;
    localparam t_term V_TO_RED   = 21'sd1634;
    localparam t_term V_TO_GREEN = 21'sd833;
    localparam t_term U_TO_GREEN = 21'sd400;
    localparam t_term U_TO_BLUE  = 21'sd2066;

    // Number of pixels in one 2x2 block.
    localparam int NUM_PIX = 4;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue_diff;
        logic [7:0] chroma_red_diff;
    } t_block_in;

    typedef struct packed {
        logic [7:0] red_top_left;
        logic [7:0] green_top_left;
        logic [7:0] blue_top_left;
        logic [7:0] red_top_right;
        logic [7:0] green_top_right;
        logic [7:0] blue_top_right;
        logic [7:0] red_bottom_left;
        logic [7:0] green_bottom_left;
        logic [7:0] blue_bottom_left;
        logic [7:0] red_bottom_right;
        logic [7:0] green_bottom_right;
        logic [7:0] blue_bottom_right;
    } t_block_out;

endpackage

// ===== hw/rtl/nv21rgb_pix.sv =====
// Per-pixel back end: chroma add, then shift and saturate, two register stages.
module nv21rgb_pix (
    input  logic                i_clk,
    input  nv21rgb_pkg::t_term  i_yterm,
    input  nv21rgb_pkg::t_term  i_red_add,
    input  nv21rgb_pkg::t_term  i_green_v,
    input  nv21rgb_pkg::t_term  i_green_u,
    input  nv21rgb_pkg::t_term  i_blue_add,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue
);
    import nv21rgb_pkg::*;

    localparam int SHIFT_W = TERM_W - FRAC_BITS;

    t_term r_red_sum, r_green_sum, r_blue_sum;
    logic [7:0] n_red, n_green, n_blue;

    // Arithmetic shift (floor), then clamp to 0..255.
    function automatic logic [7:0] sat(input t_term sum);
        logic signed [SHIFT_W-1:0] sh;
        sh = SHIFT_W'(sum >>> FRAC_BITS);
        if (sh < 0) begin
            return 8'd0;
        end else if (sh > $signed({3'b000, PIXEL_MAX})) begin
            return PIXEL_MAX;
        end else begin
            return sh[7:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        r_red_sum   <= i_yterm + i_red_add;
        r_green_sum <= i_yterm - i_green_v - i_green_u;
        r_blue_sum  <= i_yterm + i_blue_add;
    end

    always_comb begin
        n_red   = sat(r_red_sum);
        n_green = sat(r_green_sum);
        n_blue  = sat(r_blue_sum);
    end

    always_ff @(posedge i_clk) begin
        o_red   <= n_red;
        o_green <= n_green;
        o_blue  <= n_blue;
    end

endmodule

// ===== hw/rtl/nv21_block_to_rgb_top.sv =====
// Top level of the NV21 2x2 block to RGB converter (BT.601, 10 fraction bits).
//
//  channel   | strobe / hold   | payload    | beat
//  ----------+-----------------+------------+-----------------------------
//  block in  | start / busy    | i_block    | four Y samples plus U and V
//  rgb out   | o_valid / none  | o_pixels   | twelve saturated RGB bytes
//
// One beat enters per clock; busy never rises because no stage can stall.
// The pipeline stages are offset removal, multipliers, chroma add, then
// shift and saturate, each ending in a register.
// Reset (synchronous, active low) clears only the valid bits; data
// registers free-run and are ignored while their valid bit is low.
// The receiver takes each result in the single cycle o_valid is high.

`include "nv21_block_to_rgb_top_macros.svh"

module nv21_block_to_rgb_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  nv21rgb_pkg::t_block_in  i_block,
    output logic                    o_valid,
    output nv21rgb_pkg::t_block_out o_pixels
);
    import nv21rgb_pkg::*;

    // Valid bits that follow the data through the four stages.
    logic r_v1, r_v2, r_v3, r_v4;

    // Stage 1: offset-removed samples. Y below 16 is forced to zero here,
    // which is the same as clamping the negative luma term.
    logic [7:0]        n_luma [NUM_PIX];
    logic [7:0]        r_ym   [NUM_PIX];
    logic signed [8:0] r_u, r_v;

    // Stage 2: products.
    t_term r_yterm [NUM_PIX];
    t_term r_red_add, r_green_v, r_green_u, r_blue_add;

    logic [7:0] w_red   [NUM_PIX];
    logic [7:0] w_green [NUM_PIX];
    logic [7:0] w_blue  [NUM_PIX];

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        n_luma[0] = i_block.luma_top_left;
        n_luma[1] = i_block.luma_top_right;
        n_luma[2] = i_block.luma_bottom_left;
        n_luma[3] = i_block.luma_bottom_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage 1 data.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PIX; p++) begin
            r_ym[p] <= (n_luma[p] < LUMA_OFFSET) ? 8'd0 : n_luma[p] - LUMA_OFFSET;
        end
        r_u <= $signed({1'b0, i_block.chroma_blue_diff} - CHROMA_OFFSET);
        r_v <= $signed({1'b0, i_block.chroma_red_diff} - CHROMA_OFFSET);
    end

    // Stage 2: one constant multiply per term; green keeps its two parts
    // apart and they are folded in with the luma term in the next stage.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PIX; p++) begin
            r_yterm[p] <= t_term'($signed({1'b0, r_ym[p]})) * LUMA_GAIN;
        end
        r_red_add  <= t_term'(r_v) * V_TO_RED;
        r_green_v  <= t_term'(r_v) * V_TO_GREEN;
        r_green_u  <= t_term'(r_u) * U_TO_GREEN;
        r_blue_add <= t_term'(r_u) * U_TO_BLUE;
    end

    // Stages 3 and 4, one back end per pixel.
    for (genvar p = 0; p < NUM_PIX; p++) begin : g_pix
        nv21rgb_pix u_pix (
            .i_clk      (i_clk),
            .i_yterm    (r_yterm[p]),
            .i_red_add  (r_red_add),
            .i_green_v  (r_green_v),
            .i_green_u  (r_green_u),
            .i_blue_add (r_blue_add),
            .o_red      (w_red[p]),
            .o_green    (w_green[p]),
            .o_blue     (w_blue[p])
        );
    end

    assign o_valid = r_v4;

    always_comb begin
        o_pixels.red_top_left       = w_red[0];
        o_pixels.green_top_left     = w_green[0];
        o_pixels.blue_top_left      = w_blue[0];
        o_pixels.red_top_right      = w_red[1];
        o_pixels.green_top_right    = w_green[1];
        o_pixels.blue_top_right     = w_blue[1];
        o_pixels.red_bottom_left    = w_red[2];
        o_pixels.green_bottom_left  = w_green[2];
        o_pixels.blue_bottom_left   = w_blue[2];
        o_pixels.red_bottom_right   = w_red[3];
        o_pixels.green_bottom_right = w_green[3];
        o_pixels.blue_bottom_right  = w_blue[3];
    end

    // Every accepted beat comes out on o_valid once it has passed r_v1 to r_v4.
    `NRGB_ASSERT_IMPL(a_latency, accept, ##4 o_valid)
    // No result without a matching earlier accepted beat.
    `NRGB_ASSERT_IMPL(a_no_phantom, o_valid, $past(accept, 4))
    // An idle input empties the pipe: the valid bit after the chroma add
    // follows the one before it.
    `NRGB_ASSERT_NEXT(a_pipe_order, !r_v2, !r_v3)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the NV21 2x2 block to RGB converter.
module tb;

    import nv21rgb_pkg::*;

    // Conversion constants (BT.601, 10 fraction bits), kept local to the predictor.
    localparam int Y_GAIN      = 1192;
    localparam int Y_BLACK     = 16;
    localparam int C_MID       = 128;
    localparam int CR_RED      = 1634;
    localparam int CR_GREEN    = 833;
    localparam int CB_GREEN    = 400;
    localparam int CB_BLUE     = 2066;
    localparam int FRAC        = 10;
    localparam int COLOR_MAX   = 255;

    // Drain for longer than the block latency.
    localparam int DRAIN_CYCLES = 8;
    // Slowest legal run: 560 beats, each possibly followed by an idle burst, plus
    // reset and drain. Taken many times over.
    localparam int CYCLE_LIMIT  = 100000;
    localparam int MAX_REPORTS  = 10;

    localparam int NUM_FIELDS = 12;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_block_in  i_block = '0;
    logic       o_valid;
    t_block_out o_pixels;

    // Expected RGB blocks, oldest first.
    t_block_out expected_rgb[$];
    int         fail_count  = 0;
    int         cycle_count = 0;
    // Percent chance of an idle burst after each beat; 0 means back to back.
    int         idle_pct    = 0;

    nv21_block_to_rgb_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_block (i_block),
        .o_valid (o_valid),
        .o_pixels(o_pixels)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Arithmetic shift (floor) out of the fraction bits, then clamp to a byte.
    function automatic logic [7:0] descale_clamp(input int sum);
        int q;
        q = sum >>> FRAC;
        if (q < 0) begin
            return 8'd0;
        end
        if (q > COLOR_MAX) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    // Luma term; anything below black level contributes nothing.
    function automatic int luma_term(input logic [7:0] y);
        int t;
        t = Y_GAIN * (int'(y) - Y_BLACK);
        return (t < 0) ? 0 : t;
    endfunction

    function automatic t_block_out predict_rgb(input t_block_in blk);
        int cb;
        int cr;
        int red_add;
        int green_add;
        int blue_add;
        int yt[4];
        logic [7:0] rgb[NUM_FIELDS];
        logic [NUM_FIELDS*8-1:0] flat;
        cb = int'(blk.chroma_blue_diff) - C_MID;
        cr = int'(blk.chroma_red_diff) - C_MID;
        red_add   = CR_RED * cr;
        green_add = -(CR_GREEN * cr) - (CB_GREEN * cb);
        blue_add  = CB_BLUE * cb;
        yt[0] = luma_term(blk.luma_top_left);
        yt[1] = luma_term(blk.luma_top_right);
        yt[2] = luma_term(blk.luma_bottom_left);
        yt[3] = luma_term(blk.luma_bottom_right);
        for (int p = 0; p < 4; p++) begin
            rgb[p*3 + 0] = descale_clamp(yt[p] + red_add);
            rgb[p*3 + 1] = descale_clamp(yt[p] + green_add);
            rgb[p*3 + 2] = descale_clamp(yt[p] + blue_add);
        end
        // Field order of the result struct: first field in the top byte.
        for (int k = 0; k < NUM_FIELDS; k++) begin
            flat[(NUM_FIELDS-1-k)*8 +: 8] = rgb[k];
        end
        return t_block_out'(flat);
    endfunction

    function automatic string field_name(input int k);
        string color[3];
        string pos[4];
        color = '{"red", "green", "blue"};
        pos   = '{"top_left", "top_right", "bottom_left", "bottom_right"};
        return {color[k % 3], "_", pos[k / 3]};
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: record every accepted beat, check every result beat.
    // Everything here samples pre-edge values; all drives are nonblocking.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_block_out want;
        logic [NUM_FIELDS*8-1:0] want_flat;
        logic [NUM_FIELDS*8-1:0] got_flat;
        if (i_rst_n) begin
            // Record first, so a result in the same cycle as its beat would still find its entry.
            if (start && !busy) begin
                expected_rgb.push_back(predict_rgb(i_block));
            end
            if (o_valid) begin
                if (expected_rgb.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("ERROR: unexpected RGB beat %h", o_pixels);
                    end
                end else begin
                    want      = expected_rgb.pop_front();
                    want_flat = want;
                    got_flat  = o_pixels;
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (got_flat[(NUM_FIELDS-1-k)*8 +: 8] !==
                            want_flat[(NUM_FIELDS-1-k)*8 +: 8]) begin
                            fail_count++;
                            if (fail_count <= MAX_REPORTS) begin
                                $display("ERROR: %s expected %0d got %0d",
                                         field_name(k),
                                         want_flat[(NUM_FIELDS-1-k)*8 +: 8],
                                         got_flat[(NUM_FIELDS-1-k)*8 +: 8]);
                            end
                        end
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    function automatic t_block_in random_block();
        logic [63:0] r;
        t_block_in blk;
        r   = {$urandom(), $urandom()};
        blk = r[47:0];
        return blk;
    endfunction

    // Hold start high with the beat until the block takes it.
    // Called right after a rising edge; returns after the accepting edge and any idle burst.
    task automatic send_block(input t_block_in blk);
        int gap;
        start   <= 1'b1;
        i_block <= blk;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        // Optional idle burst; payload is replaced with a random one to show it is ignored.
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            gap = $urandom_range(8, 1);
            start   <= 1'b0;
            i_block <= random_block();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [7:0] ytl, input logic [7:0] ytr,
                               input logic [7:0] ybl, input logic [7:0] ybr,
                               input logic [7:0] cb, input logic [7:0] cr);
        t_block_in blk;
        blk.luma_top_left     = ytl;
        blk.luma_top_right    = ytr;
        blk.luma_bottom_left  = ybl;
        blk.luma_bottom_right = ybr;
        blk.chroma_blue_diff  = cb;
        blk.chroma_red_diff   = cr;
        send_block(blk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, black level, dark luma, chroma extremes, pixel order.
    task automatic test_directed();
        idle_pct = 30;
        send_fields(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
        send_fields(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_fields(8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd128);
        // dark luma: below black level must clamp the luma term to zero
        send_fields(8'd15,  8'd14,  8'd0,   8'd16,  8'd128, 8'd128);
        send_fields(8'd15,  8'd1,   8'd0,   8'd8,   8'd255, 8'd255);
        send_fields(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128);
        send_fields(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128);
        // distinct luma per corner catches swapped pixels
        send_fields(8'd0,   8'd85,  8'd170, 8'd255, 8'd128, 8'd128);
        send_fields(8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd128);
        send_fields(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128);
        send_fields(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd0);
        send_fields(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd255);
        // U/V order: the two must not be swapped
        send_fields(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0);
        send_fields(8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255);
        // negative sums: shift must floor, then clamp low
        send_fields(8'd16,  8'd17,  8'd18,  8'd20,  8'd0,   8'd0);
        send_fields(8'd17,  8'd17,  8'd17,  8'd17,  8'd127, 8'd129);
        send_fields(8'd170, 8'd85,  8'd170, 8'd85,  8'd170, 8'd85);
        send_fields(8'd85,  8'd170, 8'd85,  8'd170, 8'd85,  8'd170);
        send_fields(8'd200, 8'd50,  8'd16,  8'd235, 8'd200, 8'd60);
        send_fields(8'd240, 8'd10,  8'd129, 8'd127, 8'd127, 8'd129);
    endtask

    // Fully random beats, in chunks of varying idle density.
    task automatic test_random_blocks(input int count);
        int pct_choice[3];
        pct_choice = '{0, 20, 60};
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                idle_pct = pct_choice[$urandom_range(2, 0)];
            end
            send_block(random_block());
        end
    endtask

    // Samples pushed toward the clamp points on both ends.
    task automatic test_saturation_corners(input int count);
        t_block_in blk;
        logic [7:0] y[4];
        idle_pct = 25;
        for (int i = 0; i < count; i++) begin
            for (int p = 0; p < 4; p++) begin
                y[p] = $urandom_range(1, 0) ? 8'($urandom_range(31, 0))
                                            : 8'($urandom_range(255, 224));
            end
            blk.luma_top_left     = y[0];
            blk.luma_top_right    = y[1];
            blk.luma_bottom_left  = y[2];
            blk.luma_bottom_right = y[3];
            blk.chroma_blue_diff  = $urandom_range(1, 0) ? 8'($urandom_range(15, 0))
                                                        : 8'($urandom_range(255, 240));
            blk.chroma_red_diff   = $urandom_range(1, 0) ? 8'($urandom_range(15, 0))
                                                        : 8'($urandom_range(255, 240));
            send_block(blk);
        end
    endtask

    // Final stretch: one beat per clock, no idling.
    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        for (int i = 0; i < count; i++) begin
            send_block(random_block());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_blocks(420);
        test_saturation_corners(60);
        test_back_to_back(60);

        start <= 1'b0;
        while (expected_rgb.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_rgb.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
